[sv/asa_pkg.sv]
// shared types and constants of the shelf atlas allocator
package asa_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int ROW_CW    = $clog2(MAX_ROWS + 1);
    localparam int SIZE_BITS = 15;
    localparam int H_W       = 13;
    localparam int POS_W     = 14;
    localparam int TRY_W     = $clog2(SIZE_BITS + 2);
    localparam int TENTH_W   = 10;
    localparam int TENTH_MUL = 6554;

    localparam logic [H_W-1:0] HGT_MAX = {H_W{1'b1}};

    // register indexes
    localparam logic [1:0] REG_START_W = 2'd0;
    localparam logic [1:0] REG_START_H = 2'd1;
    localparam logic [1:0] REG_MAX_SZ  = 2'd2;

    // status codes
    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_MAX    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]     top;
        logic [H_W-1:0]       span;
        logic [SIZE_BITS-1:0] used;
    } t_row;

endpackage

[sv/asa_ram.sv]
// generic single write port ram with registered read
module asa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/atlas_shelf_allocator.sv]
// top level of the shelf packing texture atlas allocator
//
// Each request (req_width, req_height) is placed into the first stored row
// that fits, otherwise a new row is opened below the used part, doubling the
// atlas until it fits or the maximum size is hit. A request is taken when
// start is high and busy is low; busy stays high until the result is ready,
// and the result is shown for exactly one cycle with o_done high. The
// receiver cannot stall, so it must take the result in that cycle. When all
// 64 rows are in use, no new row is opened and the result is table full.
// The row table is read one row per cycle through a single registered ram
// port; a request that opens a new row first scans every row in use, then
// doubles the atlas as needed before the row is written. o_done is high in
// the first cycle that busy is low. The configuration port is always ready;
// write it only while the block is idle.
module atlas_shelf_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [asa_pkg::H_W-1:0]        i_req_width,
    input  logic [asa_pkg::H_W-1:0]        i_req_height,
    output logic                           o_done,
    output logic [asa_pkg::POS_W-1:0]      o_pos_x,
    output logic [asa_pkg::POS_W-1:0]      o_pos_y,
    output logic [1:0]                     o_status,
    output logic [asa_pkg::SIZE_BITS-1:0]  o_atlas_w,
    output logic [asa_pkg::SIZE_BITS-1:0]  o_atlas_h,
    output logic                           o_grew,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [asa_pkg::SIZE_BITS-1:0]  i_cfg_data
);
    import asa_pkg::*;

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_GROW = 3'b100
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [SIZE_BITS-1:0] r_start_w, n_start_w;
    logic [SIZE_BITS-1:0] r_start_h, n_start_h;
    logic [SIZE_BITS-1:0] r_max_sz,  n_max_sz;

    // atlas state
    logic [ROW_CW-1:0]    r_rows, n_rows;
    logic [SIZE_BITS-1:0] r_next, n_next;
    logic [SIZE_BITS-1:0] r_cur_w, n_cur_w;
    logic [SIZE_BITS-1:0] r_cur_h, n_cur_h;

    // request working registers
    logic [H_W-1:0]       r_w, n_w;
    logic [H_W-1:0]       r_h, n_h;
    logic [TENTH_W-1:0]   r_tenth, n_tenth;
    logic [H_W-1:0]       r_rh, n_rh;
    logic [ROW_CW-1:0]    r_idx, n_idx;
    logic [ROW_AW-1:0]    r_cidx, n_cidx;
    logic                 r_dv, n_dv;
    logic [TRY_W-1:0]     r_tries, n_tries;
    logic                 r_grew, n_grew;

    // result registers
    logic                 r_done, n_done;
    logic [POS_W-1:0]     r_pos_x, n_pos_x;
    logic [POS_W-1:0]     r_pos_y, n_pos_y;
    logic [1:0]           r_status, n_status;
    logic [SIZE_BITS-1:0] r_out_w, n_out_w;
    logic [SIZE_BITS-1:0] r_out_h, n_out_h;
    logic                 r_out_g, n_out_g;

    // row table port
    logic                 ram_we;
    logic [ROW_AW-1:0]    ram_waddr;
    t_row                 ram_wdata;
    logic [ROW_AW-1:0]    ram_raddr;
    t_row                 ram_rdata;

    // shared datapath
    logic [2*H_W-1:0]     tenth_prod;
    logic [H_W+3:0]       h_x10;
    logic [H_W+3:0]       span_x7;
    logic [SIZE_BITS:0]   used_sum;
    logic                 fit;
    logic [H_W:0]         rh_sum;
    logic [H_W-1:0]       rh_sat;
    logic [SIZE_BITS:0]   row_end;
    logic                 need_grow;
    logic [SIZE_BITS:0]   dbl_w;
    logic [SIZE_BITS:0]   dbl_h;
    logic                 grow_fail;

    asa_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // h/10 by reciprocal, exact for 13 bit heights
    assign tenth_prod = (2*H_W)'(i_req_height) * (2*H_W)'(TENTH_MUL);

    // first fit test on the row read out last cycle
    assign h_x10    = {1'b0, r_h, 3'b000} + {3'b000, r_h, 1'b0};
    assign span_x7  = {1'b0, ram_rdata.span, 3'b000} - {4'b0000, ram_rdata.span};
    assign used_sum = {1'b0, ram_rdata.used} + (SIZE_BITS+1)'(r_w);
    assign fit      = r_dv && (r_h <= ram_rdata.span) && (h_x10 >= span_x7) &&
                      (used_sum <= {1'b0, r_cur_w});

    // new row height, saturated
    assign rh_sum = {1'b0, r_h} + (H_W+1)'(r_tenth);
    assign rh_sat = rh_sum[H_W] ? HGT_MAX : rh_sum[H_W-1:0];

    // doubling test
    assign row_end   = {1'b0, r_next} + (SIZE_BITS+1)'(r_rh);
    assign need_grow = (row_end >= {1'b0, r_cur_h}) ||
                       ((SIZE_BITS)'(r_w) >= r_cur_w);
    assign dbl_w     = {r_cur_w, 1'b0};
    assign dbl_h     = {r_cur_h, 1'b0};
    assign grow_fail = (r_tries > TRY_W'(SIZE_BITS)) ||
                       (dbl_w > {1'b0, r_max_sz}) || (dbl_h > {1'b0, r_max_sz});

    assign ram_raddr = r_idx[ROW_AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_start_w = r_start_w;
        n_start_h = r_start_h;
        n_max_sz  = r_max_sz;
        n_rows    = r_rows;
        n_next    = r_next;
        n_cur_w   = r_cur_w;
        n_cur_h   = r_cur_h;
        n_w       = r_w;
        n_h       = r_h;
        n_tenth   = r_tenth;
        n_rh      = r_rh;
        n_idx     = r_idx;
        n_cidx    = r_cidx;
        n_dv      = r_dv;
        n_tries   = r_tries;
        n_grew    = r_grew;
        n_done    = 1'b0;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_status  = r_status;
        n_out_w   = r_out_w;
        n_out_h   = r_out_h;
        n_out_g   = r_out_g;
        ram_we    = 1'b0;
        ram_waddr = r_cidx;
        ram_wdata = ram_rdata;

        // config write
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_W: n_start_w = i_cfg_data;
                REG_START_H: n_start_h = i_cfg_data;
                REG_MAX_SZ:  n_max_sz  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_w     = i_req_width;
                    n_h     = i_req_height;
                    n_tenth = tenth_prod[2*H_W-1 -: TENTH_W];
                    n_idx   = '0;
                    n_dv    = 1'b0;
                    n_tries = '0;
                    n_grew  = 1'b0;
                    // empty table restarts from the start size
                    if (r_rows == '0) begin
                        n_cur_w = (r_start_w == '0) ? SIZE_BITS'(1) : r_start_w;
                        n_cur_h = (r_start_h == '0) ? SIZE_BITS'(1) : r_start_h;
                        n_next  = '0;
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (fit) begin
                    // place in existing row, widen its used span
                    ram_we         = 1'b1;
                    ram_waddr      = r_cidx;
                    ram_wdata      = ram_rdata;
                    ram_wdata.used = used_sum[SIZE_BITS-1:0];
                    n_done   = 1'b1;
                    n_pos_x  = ram_rdata.used[POS_W-1:0];
                    n_pos_y  = ram_rdata.top;
                    n_status = ST_PLACED;
                    n_out_w  = r_cur_w;
                    n_out_h  = r_cur_h;
                    n_out_g  = 1'b0;
                    n_state  = S_IDLE;
                end else if (r_idx == r_rows) begin
                    if (r_rows == ROW_CW'(MAX_ROWS)) begin
                        // table full
                        n_done   = 1'b1;
                        n_pos_x  = '0;
                        n_pos_y  = '0;
                        n_status = ST_FULL;
                        n_out_w  = r_cur_w;
                        n_out_h  = r_cur_h;
                        n_out_g  = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_rh    = rh_sat;
                        n_state = S_GROW;
                    end
                end else begin
                    n_cidx = r_idx[ROW_AW-1:0];
                    n_dv   = 1'b1;
                    n_idx  = r_idx + ROW_CW'(1);
                end
            end
            S_GROW: begin
                if (!need_grow) begin
                    // open new row below the used part
                    ram_we         = 1'b1;
                    ram_waddr      = r_rows[ROW_AW-1:0];
                    ram_wdata.top  = r_next[POS_W-1:0];
                    ram_wdata.span = r_rh;
                    ram_wdata.used = SIZE_BITS'(r_w);
                    n_done   = 1'b1;
                    n_pos_x  = '0;
                    n_pos_y  = r_next[POS_W-1:0];
                    n_status = ST_PLACED;
                    n_out_w  = r_cur_w;
                    n_out_h  = r_cur_h;
                    n_out_g  = r_grew;
                    n_next   = row_end[SIZE_BITS-1:0];
                    n_rows   = r_rows + ROW_CW'(1);
                    n_state  = S_IDLE;
                end else if (grow_fail) begin
                    n_done   = 1'b1;
                    n_pos_x  = '0;
                    n_pos_y  = '0;
                    n_status = ST_MAX;
                    n_out_w  = r_cur_w;
                    n_out_h  = r_cur_h;
                    n_out_g  = r_grew;
                    n_state  = S_IDLE;
                end else begin
                    n_cur_w = dbl_w[SIZE_BITS-1:0];
                    n_cur_h = dbl_h[SIZE_BITS-1:0];
                    n_grew  = 1'b1;
                    n_tries = r_tries + TRY_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start_w <= SIZE_BITS'(128);
            r_start_h <= SIZE_BITS'(128);
            r_max_sz  <= SIZE_BITS'(4096);
            r_rows    <= '0;
            r_next    <= '0;
            r_cur_w   <= SIZE_BITS'(128);
            r_cur_h   <= SIZE_BITS'(128);
            r_idx     <= '0;
            r_dv      <= 1'b0;
            r_tries   <= '0;
            r_grew    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_start_w <= n_start_w;
            r_start_h <= n_start_h;
            r_max_sz  <= n_max_sz;
            r_rows    <= n_rows;
            r_next    <= n_next;
            r_cur_w   <= n_cur_w;
            r_cur_h   <= n_cur_h;
            r_idx     <= n_idx;
            r_dv      <= n_dv;
            r_tries   <= n_tries;
            r_grew    <= n_grew;
            r_done    <= n_done;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_h      <= n_h;
        r_tenth  <= n_tenth;
        r_rh     <= n_rh;
        r_cidx   <= n_cidx;
        r_pos_x  <= n_pos_x;
        r_pos_y  <= n_pos_y;
        r_status <= n_status;
        r_out_w  <= n_out_w;
        r_out_h  <= n_out_h;
        r_out_g  <= n_out_g;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_status    = r_status;
    assign o_atlas_w   = r_out_w;
    assign o_atlas_h   = r_out_h;
    assign o_grew      = r_out_g;

`ifndef SYNTH
    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= ROW_CW'(MAX_ROWS))
        else $error("row count above table depth");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(busy) && !busy) |-> o_done)
        else $error("request finished without a result strobe");

    a_fail_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_PLACED) |-> (o_pos_x == '0 && o_pos_y == '0))
        else $error("failed request carries a position");

    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> !o_grew)
        else $error("full table result reports growth");

    a_atlas_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_atlas_w != '0 && o_atlas_h != '0))
        else $error("atlas size reported as zero");
`endif

endmodule

[dv/tb_top.sv]
// self-checking testbench of the shelf packing atlas allocator
module tb_top;
    import asa_pkg::*;

    localparam int          HALF_PERIOD    = 5;
    localparam int          RESET_CYCLES   = 12;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int unsigned REQ_MAX        = (1 << H_W) - 1;
    localparam int unsigned REG_MAX        = (1 << SIZE_BITS) - 1;
    // index past the register list, the block must ignore it
    localparam logic [1:0]  REG_UNUSED     = 2'd3;

    // one placement result as the block reports it
    typedef struct packed {
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [1:0]           status;
        logic [SIZE_BITS-1:0] atlas_w;
        logic [SIZE_BITS-1:0] atlas_h;
        logic                 grew;
    } t_placement;

    // mirror of the shelf table plus the queue of placements still owed
    class t_shelf_scoreboard;
        logic [SIZE_BITS-1:0] start_w;
        logic [SIZE_BITS-1:0] start_h;
        logic [SIZE_BITS-1:0] max_size;
        t_row                 rows [MAX_ROWS];
        int unsigned          rows_in_use;
        logic [SIZE_BITS-1:0] next_top;
        logic [SIZE_BITS-1:0] cur_w;
        logic [SIZE_BITS-1:0] cur_h;
        t_placement           expected_places[$];
        int unsigned          errors;
        int unsigned          n_requests;
        int unsigned          n_placed;
        int unsigned          n_at_max;
        int unsigned          n_full;
        int unsigned          n_grew;
        int unsigned          n_writes;

        function new();
            start_w     = 15'd128;
            start_h     = 15'd128;
            max_size    = 15'd4096;
            rows_in_use = 0;
            next_top    = '0;
            cur_w       = start_w;
            cur_h       = start_h;
            errors      = 0;
            n_requests  = 0;
            n_placed    = 0;
            n_at_max    = 0;
            n_full      = 0;
            n_grew      = 0;
            n_writes    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [SIZE_BITS-1:0] data);
            n_writes++;
            case (idx)
                REG_START_W: start_w  = data;
                REG_START_H: start_h  = data;
                REG_MAX_SZ:  max_size = data;
                default: ;
            endcase
        endfunction

        // first-fit over the rows, else open a new row after doubling
        function t_placement place_rect(logic [H_W-1:0] w_in, logic [H_W-1:0] h_in);
            t_placement  p;
            int unsigned w;
            int unsigned h;
            int unsigned rh;
            int unsigned span;
            int unsigned tries;
            int unsigned i;
            logic        grew;
            w     = w_in;
            h     = h_in;
            tries = 0;
            grew  = 1'b0;
            p     = '0;
            p.status = ST_PLACED;
            // an empty table always restarts from the start size
            if (rows_in_use == 0) begin
                cur_w    = (start_w == 0) ? 15'd1 : start_w;
                cur_h    = (start_h == 0) ? 15'd1 : start_h;
                next_top = '0;
            end
            for (i = 0; i < rows_in_use; i++) begin
                span = rows[i].span;
                if (h > span || 10 * h < 7 * span)
                    continue;
                if (rows[i].used + w > cur_w)
                    continue;
                p.pos_x      = rows[i].used[POS_W-1:0];
                p.pos_y      = rows[i].top;
                p.atlas_w    = cur_w;
                p.atlas_h    = cur_h;
                rows[i].used = rows[i].used + w;
                return p;
            end
            if (rows_in_use >= MAX_ROWS) begin
                p.status  = ST_FULL;
                p.atlas_w = cur_w;
                p.atlas_h = cur_h;
                return p;
            end
            rh = h + h / 10;
            if (rh > HGT_MAX)
                rh = HGT_MAX;
            while (next_top + rh >= cur_h || w >= cur_w) begin
                if (tries > SIZE_BITS || cur_w * 2 > max_size || cur_h * 2 > max_size) begin
                    // doublings made so far are kept
                    p.status  = ST_MAX;
                    p.grew    = grew;
                    p.atlas_w = cur_w;
                    p.atlas_h = cur_h;
                    return p;
                end
                cur_w = cur_w * 2;
                cur_h = cur_h * 2;
                grew  = 1'b1;
                tries++;
            end
            rows[rows_in_use] = '{top: next_top[POS_W-1:0], span: rh[H_W-1:0],
                                  used: w[SIZE_BITS-1:0]};
            p.pos_y   = next_top[POS_W-1:0];
            p.grew    = grew;
            p.atlas_w = cur_w;
            p.atlas_h = cur_h;
            next_top  = next_top + rh;
            rows_in_use++;
            return p;
        endfunction

        function void note_request(logic [H_W-1:0] w, logic [H_W-1:0] h);
            n_requests++;
            expected_places.push_back(place_rect(w, h));
        endfunction

        function void check_field(string field, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_placement got);
            t_placement exp_p;
            if (expected_places.size() == 0) begin
                $error("result with no request pending");
                errors++;
                return;
            end
            exp_p = expected_places.pop_front();
            check_field("pos_x",   exp_p.pos_x,   got.pos_x);
            check_field("pos_y",   exp_p.pos_y,   got.pos_y);
            check_field("status",  exp_p.status,  got.status);
            check_field("atlas_w", exp_p.atlas_w, got.atlas_w);
            check_field("atlas_h", exp_p.atlas_h, got.atlas_h);
            check_field("grew",    exp_p.grew,    got.grew);
            case (exp_p.status)
                ST_PLACED: n_placed++;
                ST_MAX:    n_at_max++;
                default:   n_full++;
            endcase
            if (exp_p.grew)
                n_grew++;
        endfunction

        function int unsigned pending();
            return expected_places.size();
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic [H_W-1:0]       i_req_width  = '0;
    logic [H_W-1:0]       i_req_height = '0;
    logic                 i_cfg_valid  = 1'b0;
    logic [1:0]           i_cfg_index  = REG_START_W;
    logic [SIZE_BITS-1:0] i_cfg_data   = '0;

    logic                 busy;
    logic                 o_done;
    logic [POS_W-1:0]     o_pos_x;
    logic [POS_W-1:0]     o_pos_y;
    logic [1:0]           o_status;
    logic [SIZE_BITS-1:0] o_atlas_w;
    logic [SIZE_BITS-1:0] o_atlas_h;
    logic                 o_grew;
    logic                 o_cfg_ready;

    t_shelf_scoreboard sb;
    int unsigned       idle_cycles = 0;
    // when set, requests follow each other with no gap at all
    bit                no_idle     = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    atlas_shelf_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_width  (i_req_width),
        .i_req_height (i_req_height),
        .o_done       (o_done),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_status     (o_status),
        .o_atlas_w    (o_atlas_w),
        .o_atlas_h    (o_atlas_h),
        .o_grew       (o_grew),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // monitor: everything is sampled at the rising edge, inputs move on the
    // falling edge, so nothing here races the drivers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // note before check so a back-to-back request cannot overtake
            if (start && !busy)
                sb.note_request(i_req_width, i_req_height);
            if (o_done)
                sb.check_result('{pos_x: o_pos_x, pos_y: o_pos_y, status: o_status,
                                  atlas_w: o_atlas_w, atlas_h: o_atlas_h, grew: o_grew});
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // watchdog on cycles where no request, result or write moves
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one, none inside a burst
    function automatic int unsigned pick_gap();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 150);
        return $urandom_range(0, 3);
    endfunction

    // present one request and hold it until an edge with busy low takes it;
    // returns at the falling edge after acceptance with start still high
    task automatic send_req(input logic [H_W-1:0] w, input logic [H_W-1:0] h);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_req_width  <= w;
        i_req_height <= h;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    // wait for every owed result, then a little longer for the block to settle
    task automatic wait_idle();
        while (sb.pending() != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic set_reg(input logic [1:0] idx, input int unsigned data);
        start <= 1'b0;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[SIZE_BITS-1:0];
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random phase: mostly rectangles drawn from a few height classes so that
    // rows get reused and the table fills, plus full-range noise and corners
    task automatic run_phase(input int unsigned count, input int unsigned base_lo,
                             input int unsigned base_hi);
        int unsigned bases[4];
        int unsigned b;
        int unsigned lo;
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int unsigned corner[4];
        corner = '{0, 1, 4096, REQ_MAX};
        foreach (bases[k])
            bases[k] = $urandom_range(base_lo, base_hi);
        for (int n = 0; n < count; n++) begin
            // toggle bursts without gaps every so often
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                w = $urandom_range(0, REQ_MAX);
                h = $urandom_range(0, REQ_MAX);
            end else if (r < 13) begin
                w = corner[$urandom_range(0, 3)];
                h = corner[$urandom_range(0, 3)];
            end else begin
                b  = bases[$urandom_range(0, 3)];
                lo = (b * 3) / 4 + 1;
                if (lo > b)
                    lo = b;
                h = $urandom_range(lo, b);
                w = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1024)
                                                 : $urandom_range(1, 48);
            end
            send_req(w[H_W-1:0], h[H_W-1:0]);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part ----
        // empty table, reset sizes: growth runs into the maximum and is kept
        send_req(13'd4096, 13'd4096);
        // table still empty, so the start size is reloaded first
        send_req(REQ_MAX[H_W-1:0], REQ_MAX[H_W-1:0]);

        // zero start size is taken as one, maximum of one forbids growth
        set_reg(REG_START_W, 0);
        set_reg(REG_START_H, 0);
        set_reg(REG_MAX_SZ, 1);
        set_reg(REG_UNUSED, REG_MAX);
        send_req(13'd1, 13'd1);
        send_req(13'd5000, 13'd3);

        // very wide start, doubling the width would overshoot at once
        set_reg(REG_START_W, REG_MAX);
        set_reg(REG_START_H, 1);
        set_reg(REG_MAX_SZ, 16384);
        send_req(13'd100, 13'd100);

        // sane start size, first rows get opened
        set_reg(REG_START_W, 64);
        set_reg(REG_START_H, 64);
        set_reg(REG_MAX_SZ, 4096);
        send_req(13'd64, 13'd20);     // grows once, opens the first row
        send_req(13'd64, 13'd16);     // fills that row to the atlas edge
        send_req(13'd1, 13'd22);      // row is full, opens a second row
        send_req(13'd1, 13'd15);      // below the 0.7 band of both rows
        send_req(13'd0, 13'd0);       // zero-height row
        send_req(13'd0, 13'd0);       // lands in the zero-height row
        send_req(REQ_MAX[H_W-1:0], 13'd1);   // too wide, grows up to the max
        send_req(13'd4095, 13'd4096); // too tall at the maximum size

        // top maximum: tall rows with the row height saturated
        set_reg(REG_MAX_SZ, REG_MAX);
        send_req(13'd4095, 13'd4096);
        send_req(REQ_MAX[H_W-1:0], REQ_MAX[H_W-1:0]);
        send_req(REQ_MAX[H_W-1:0], REQ_MAX[H_W-1:0]);
        send_req(REQ_MAX[H_W-1:0], REQ_MAX[H_W-1:0]);

        // ---- random part, new register settings before each phase ----
        set_reg(REG_MAX_SZ, 4096);
        set_reg(REG_START_W, $urandom_range(1, 16384));
        run_phase(550, 2, 64);

        set_reg(REG_MAX_SZ, REG_MAX);
        set_reg(REG_START_H, 16384);
        run_phase(400, 8, 200);

        // lowest maximum: nothing may grow any more
        set_reg(REG_MAX_SZ, 1);
        run_phase(250, 2, 64);

        set_reg(REG_MAX_SZ, $urandom_range(1, 16384));
        set_reg(REG_START_W, $urandom_range(0, REG_MAX));
        set_reg(REG_START_H, $urandom_range(0, REG_MAX));
        run_phase(330, 2, 120);

        // drain and let the block go quiet
        start <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d register writes", sb.n_requests,
                 sb.n_writes);
        $display("outcomes: %0d placed, %0d at maximum size, %0d table full, %0d grew",
                 sb.n_placed, sb.n_at_max, sb.n_full, sb.n_grew);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
